// ----- hdl/nps_pkg.sv -----
`timescale 1ns / 1ps

package nps_pkg;

    localparam int DEPTH  = 1024;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 11;
    localparam int DIST_W = VAL_W + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic                     valid;
        logic                     search;
        logic                     insert;
        logic                     full;
        logic [CNT_W-1:0]         count;
        logic signed [VAL_W-1:0]  value;
        logic [DIST_W-1:0]        best_dist;
        logic [POS_W-1:0]         best_pos;
    } token_t;

endpackage

// ----- hdl/nps_in_if.sv -----
`timescale 1ns / 1ps

interface nps_in_if;

    logic                             valid;
    logic                             ready;
    logic signed [nps_pkg::VAL_W-1:0] value;
    logic                             first_of_sequence;

    modport source (output valid, output value, output first_of_sequence, input ready);
    modport sink (input valid, input value, input first_of_sequence, output ready);

endinterface

// ----- hdl/nps_out_if.sv -----
`timescale 1ns / 1ps

interface nps_out_if;

    logic                      valid;
    logic                      ready;
    logic [nps_pkg::POS_W-1:0] nearest_position;
    logic                      store_full;

    modport source (output valid, output nearest_position, output store_full, input ready);
    modport sink (input valid, input nearest_position, input store_full, output ready);

endinterface

// ----- hdl/nps_front.sv -----
`timescale 1ns / 1ps

module nps_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic signed [nps_pkg::VAL_W-1:0] value,
    input  logic                             first_of_sequence,
    output nps_pkg::token_t                  token
);
    import nps_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             start;
    logic             full;

    assign start = first_of_sequence || (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        token.valid     = fire;
        token.search    = !start;
        token.insert    = start || !full;
        token.full      = !start && full;
        token.count     = start ? '0 : count_reg;
        token.value     = value;
        token.best_dist = '0;
        token.best_pos  = '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (start)
            begin
                count_next = CNT_W'(1);
            end
            else if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/nps_cell.sv -----
`timescale 1ns / 1ps

module nps_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [nps_pkg::IDX_W-1:0] idx,
    input  nps_pkg::token_t          token_in,
    output nps_pkg::token_t          token_out
);
    import nps_pkg::*;

    token_t                   token_reg;
    token_t                   token_next;
    logic signed [VAL_W-1:0]  store_reg;
    logic signed [DIST_W-1:0] diff;
    logic [DIST_W-1:0]        abs_diff;
    logic [CNT_W-1:0]         slot;
    logic                     occupied;
    logic                     take;

    assign slot     = CNT_W'(idx);
    assign occupied = slot < token_in.count;
    assign diff     = {token_in.value[VAL_W-1], token_in.value}
                    - {store_reg[VAL_W-1], store_reg};
    assign abs_diff = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    assign take     = token_in.search && occupied
                    && ((idx == '0) || (abs_diff < token_in.best_dist));

    always_comb
    begin
        token_next = token_in;
        if (take)
        begin
            token_next.best_dist = abs_diff;
            token_next.best_pos  = POS_W'(slot + CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else if (advance)
        begin
            token_reg <= token_next;
        end
    end

    // append the new value when the transaction passes its slot
    always_ff @(posedge clk)
    begin
        if (advance && token_in.valid && token_in.insert && (slot == token_in.count))
        begin
            store_reg <= token_in.value;
        end
    end

    assign token_out = token_reg;

endmodule

// ----- hdl/nearest_previous_value_search.sv -----
`timescale 1ns / 1ps

// channel   modport  fields
// values    sink     value[31:0] signed, first_of_sequence
// results   source   nearest_position[10:0], store_full
//
// one value enters per cycle unless results stalls; a row of DEPTH compare cells,
// one stored entry each, moves every transaction one cell per advancing cycle, then
// the output register takes its result. the first value of a sequence gives no result.
// reset clears the entry count and every valid flag in the row; no clearing pass.
// a stall on results holds the whole row and drops values.ready in the same cycle.

module nearest_previous_value_search (
    input  logic      clk,
    input  logic      rst_n,
    nps_in_if.sink    values,
    nps_out_if.source results
);
    import nps_pkg::*;

    token_t           chain [0:DEPTH];
    logic             advance;
    logic             fire;
    logic             out_valid_reg;
    logic [POS_W-1:0] position_reg;
    logic             full_reg;

    assign advance      = !out_valid_reg || results.ready;
    assign fire         = values.valid && advance;
    assign values.ready = advance;

    nps_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .value             (values.value),
        .first_of_sequence (values.first_of_sequence),
        .token             (chain[0])
    );

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        nps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .idx       (IDX_W'(k)),
            .token_in  (chain[k]),
            .token_out (chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[DEPTH].valid && chain[DEPTH].search;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            position_reg <= chain[DEPTH].best_pos;
            full_reg     <= chain[DEPTH].full;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.nearest_position = position_reg;
    assign results.store_full       = full_reg;

endmodule

// ----- hdl/nps_checker.sv -----
`timescale 1ns / 1ps

module nps_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [nps_pkg::POS_W-1:0] nearest_position,
    input logic                      store_full
);
    import nps_pkg::*;

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid;
    endproperty

    property p_out_stable;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(nearest_position) && $stable(store_full);
    endproperty

    property p_position_nonzero;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> nearest_position != '0;
    endproperty

    property p_stall_only_on_output;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready;
    endproperty

    a_out_hold: assert property (p_out_hold)
        else $error("result dropped while stalled");
    a_out_stable: assert property (p_out_stable)
        else $error("result payload changed while stalled");
    a_position_nonzero: assert property (p_position_nonzero)
        else $error("result position is zero");
    a_stall_only_on_output: assert property (p_stall_only_on_output)
        else $error("input stalled without a waiting result");

endmodule

bind nearest_previous_value_search nps_checker u_nps_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (values.valid),
    .in_ready         (values.ready),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .nearest_position (results.nearest_position),
    .store_full       (results.store_full)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import nps_pkg::*;

    localparam logic signed [VAL_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;
    localparam int N_DIRECTED   = 20;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_LIMIT  = 50000;

    typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_EXTREME, STYLE_MIXED} value_style_t;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_STRETCHES} ready_mode_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             full;
    } search_result_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    first;
        logic                    typed;
        logic                    gives;
        logic [POS_W-1:0]        pos;
        logic                    full;
    } directed_row_t;

    logic clk;
    logic rst_n;

    nps_in_if  values ();
    nps_out_if results ();

    nearest_previous_value_search dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .values  (values),
        .results (results)
    );

    search_result_t          pending_results [$];
    logic signed [VAL_W-1:0] seq_store [DEPTH];
    int unsigned             seq_len;
    int                      error_count;
    int                      results_checked;
    int                      full_results;
    int                      values_sent;
    int                      sequences_started;
    int                      burst_left;
    bit                      flush_results;
    search_result_t          oldest_result;
    directed_row_t           directed_rows [N_DIRECTED];
    ready_mode_t             ready_mode;
    int                      mode_left;
    int                      hold_left;
    logic                    hold_level;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [DIST_W-1:0] value_gap(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [VAL_W-1:0] b);
        logic signed [DIST_W-1:0] diff;
        diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return diff[DIST_W-1] ? -diff : diff;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(input value_style_t style);
        case (style)
            STYLE_WIDE:
                return $urandom;
            STYLE_NARROW:
                return VAL_W'($urandom_range(0, 16)) - 32'sd8;
            STYLE_EXTREME:
                return ($urandom_range(0, 1) == 0) ? MOST_NEGATIVE + VAL_W'($urandom_range(0, 7))
                                                   : MOST_POSITIVE - VAL_W'($urandom_range(0, 7));
            default:
                return pick_value(value_style_t'($urandom_range(0, 2)));
        endcase
    endfunction

    // start a sequence on its first value; else search the held sequence, then append unless full
    task automatic absorb_value(input logic signed [VAL_W-1:0] v, input logic first,
                                output bit gives, output search_result_t res);
        logic [DIST_W-1:0] best_gap;
        logic [DIST_W-1:0] this_gap;
        int unsigned       best_idx;
        int unsigned       i;
        gives = 1'b0;
        res   = '0;
        if (first || seq_len == 0)
        begin
            seq_store[0] = v;
            seq_len      = 1;
            sequences_started++;
        end
        else
        begin
            best_idx = 0;
            best_gap = value_gap(v, seq_store[0]);
            for (i = 1; i < seq_len; i++)
            begin
                this_gap = value_gap(v, seq_store[i]);
                if (this_gap < best_gap)
                begin
                    best_gap = this_gap;
                    best_idx = i;
                end
            end
            res.pos  = POS_W'(best_idx + 1);
            res.full = (seq_len >= DEPTH);
            if (!res.full)
            begin
                seq_store[seq_len] = v;
                seq_len++;
            end
            gives = 1'b1;
        end
    endtask

    task automatic send_value(input logic signed [VAL_W-1:0] v, input logic first);
        if (burst_left == 0)
        begin
            values.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        values.valid             <= 1'b1;
        values.value             <= v;
        values.first_of_sequence <= first;
        do @(posedge clk); while (!values.ready);
        values_sent++;
    endtask

    task automatic feed_value(input logic signed [VAL_W-1:0] v, input logic first);
        bit             gives;
        search_result_t res;
        send_value(v, first);
        absorb_value(v, first, gives, res);
        if (gives)
            pending_results.push_back(res);
    endtask

    task automatic wait_for_results();
        values.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // receiver stall pattern
    initial
    begin
        results.ready <= 1'b0;
        mode_left  = 0;
        hold_left  = 0;
        hold_level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(50, 400);
            end
            mode_left--;
            if (flush_results)
                results.ready <= 1'b1;
            else
            begin
                case (ready_mode)
                    READY_ALWAYS:
                        results.ready <= 1'b1;
                    READY_COIN:
                        results.ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:
                        results.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (hold_left == 0)
                        begin
                            hold_left  = $urandom_range(1, 30);
                            hold_level = ~hold_level;
                        end
                        hold_left--;
                        results.ready <= hold_level;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, nearest_position %0d store_full %0b",
                         $time, results.nearest_position, results.store_full);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (results.store_full === 1'b1)
                    full_results++;
                if (results.nearest_position !== oldest_result.pos)
                begin
                    $display("%0t: nearest_position expected %0d actual %0d",
                             $time, oldest_result.pos, results.nearest_position);
                    error_count++;
                end
                if (results.store_full !== oldest_result.full)
                begin
                    $display("%0t: store_full expected %0b actual %0b",
                             $time, oldest_result.full, results.store_full);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        bit             gives;
        search_result_t res;
        value_style_t   style;
        int             random_items;
        int             seq_length;
        int             drain_cycles;
        bit             long_done;
        bit             in_long;

        rst_n                    <= 1'b0;
        values.valid             <= 1'b0;
        values.value             <= '0;
        values.first_of_sequence <= 1'b0;
        flush_results     = 1'b0;
        burst_left        = 0;
        seq_len           = 0;
        error_count       = 0;
        results_checked   = 0;
        full_results      = 0;
        values_sent       = 0;
        sequences_started = 0;
        long_done         = 1'b0;

        // value, first, typed, gives, position, full
        directed_rows = '{
            '{32'sd5,          1'b0, 1'b1, 1'b0, 11'd0, 1'b0}, // no sequence started yet
            '{32'sd5,          1'b0, 1'b1, 1'b1, 11'd1, 1'b0}, // equal value
            '{32'sd7,          1'b0, 1'b1, 1'b1, 11'd1, 1'b0}, // tie, earliest wins
            '{32'sd3,          1'b0, 1'b1, 1'b1, 11'd1, 1'b0},
            '{32'sd6,          1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{MOST_NEGATIVE,   1'b1, 1'b1, 1'b0, 11'd0, 1'b0},
            '{MOST_POSITIVE,   1'b0, 1'b1, 1'b1, 11'd1, 1'b0}, // widest distance
            '{32'sd0,          1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{-32'sd1,         1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{MOST_NEGATIVE,   1'b0, 1'b1, 1'b1, 11'd1, 1'b0},
            '{MOST_POSITIVE,   1'b0, 1'b1, 1'b1, 11'd2, 1'b0},
            '{32'sd0,          1'b1, 1'b1, 1'b0, 11'd0, 1'b0},
            '{32'sd100,        1'b1, 1'b1, 1'b0, 11'd0, 1'b0}, // back-to-back restarts
            '{32'sd99,         1'b0, 1'b1, 1'b1, 11'd1, 1'b0},
            '{32'sd101,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'sh5555_5555,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'shaaaa_aaaa,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{32'sh7fff_fffe,  1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
            '{MOST_NEGATIVE,   1'b1, 1'b1, 1'b0, 11'd0, 1'b0},
            '{32'sh8000_0001,  1'b0, 1'b1, 1'b1, 11'd1, 1'b0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_value(directed_rows[r].value, directed_rows[r].first);
            absorb_value(directed_rows[r].value, directed_rows[r].first, gives, res);
            if (directed_rows[r].typed)
            begin
                if (directed_rows[r].gives)
                    pending_results.push_back('{directed_rows[r].pos, directed_rows[r].full});
            end
            else if (gives)
                pending_results.push_back(res);
        end
        wait_for_results();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            in_long = 1'b0;
            if (!long_done && random_items >= RANDOM_ITEMS / 2)
            begin
                // one sequence long enough to fill the store
                wait_for_results();
                seq_length = DEPTH + $urandom_range(2, 12);
                style      = STYLE_MIXED;
                long_done  = 1'b1;
                in_long    = 1'b1;
            end
            else
            begin
                seq_length = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
                style      = value_style_t'($urandom_range(0, 3));
            end
            for (int k = 0; k < seq_length; k++)
            begin
                feed_value(pick_value(style), k == 0);
                if (!in_long)
                    random_items++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end

        values.valid <= 1'b0;
        flush_results = 1'b1;
        drain_cycles  = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (DEPTH + 16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count += pending_results.size();
        end

        $display("sent %0d values in %0d sequences, one of them past a full store",
                 values_sent, sequences_started);
        $display("checked %0d results, %0d of them with store_full set, %0d errors",
                 results_checked, full_results, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/nps_pkg.sv
hdl/nps_in_if.sv
hdl/nps_out_if.sv
hdl/nps_front.sv
hdl/nps_cell.sv
hdl/nearest_previous_value_search.sv
hdl/nps_checker.sv
tb/testbench.sv
